FILE: rtl/wbbc_pkg.sv
// Shared types and constants for the write-back block cache policy core.
// Holds default parameters, request op codes, the result word layout and
// the scan flag bundle. No dependencies.
package wbbc_pkg;

    // Default configuration
    localparam int SLOTS_DEF   = 4;
    localparam int SPB_DEF     = 8;
    localparam int TOTAL_DEF   = 2048;

    // Fixed field widths
    localparam int SECTOR_W    = 12;
    localparam int AGE_W       = 32;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    // Request op codes
    typedef logic [1:0] op_t;
    localparam op_t OP_READ   = 2'd0;
    localparam op_t OP_WRITE  = 2'd1;
    localparam op_t OP_COMMIT = 2'd2;
    localparam op_t OP_FLUSH  = 2'd3;

    // Result word, status in bit 0
    typedef struct packed {
        logic [1:0] pad;
        logic [2:0] dirty_count;
        logic [7:0] commit_block;
        logic [1:0] commit_slot;
        logic       commit_valid;
        logic [7:0] fill_block;
        logic       fill_needed;
        logic [2:0] sector_offset;
        logic [1:0] slot;
        logic       hit;
        logic       status;
    } result_t;

    // Found bits of the slot scan
    typedef struct packed {
        logic hit;
        logic empty;
        logic clean;
        logic dirty;
    } scan_flags_t;

endpackage

FILE: rtl/wbbc_split.sv
// Sector split unit: erase block number and offset within the block.
// Divides by the block size with a reciprocal multiply; uses wbbc_pkg.
module wbbc_split #(
    parameter int SPB   = wbbc_pkg::SPB_DEF,
    parameter int BLK_W = 8,
    parameter int OFF_W = 3
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [wbbc_pkg::SECTOR_W-1:0] sector,
    output logic [BLK_W-1:0]              blk,
    output logic [OFF_W-1:0]              offset
);
    import wbbc_pkg::*;

    localparam int DivShift = SECTOR_W + $clog2(SPB);
    localparam int DivMul   = ((1 << DivShift) + SPB - 1) / SPB;
    localparam int MulW     = DivShift + 1;
    localparam int ProdW    = SECTOR_W + MulW;

    logic [SECTOR_W-1:0] sector_reg;
    logic [ProdW-1:0]    prod_reg;
    logic [ProdW-1:0]    prod_next;
    logic [ProdW-1:0]    quot;
    logic [SECTOR_W-1:0] base;
    logic [SECTOR_W-1:0] diff;

    // Multiply by the rounded-up reciprocal of the block size
    assign prod_next = ProdW'(sector) * ProdW'(DivMul);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sector_reg <= sector;
            prod_reg   <= prod_next;
        end
    end

    // Drop the fraction, then take the remainder back out
    assign quot   = prod_reg >> DivShift;
    assign blk    = quot[BLK_W-1:0];
    assign base   = quot[SECTOR_W-1:0] * SECTOR_W'(SPB);
    assign diff   = sector_reg - base;
    assign offset = diff[OFF_W-1:0];

endmodule

FILE: rtl/wbbc_scan.sv
// Slot scan unit: one tag compare and one age compare per cycle.
// Tracks first hit, first empty, oldest clean and oldest dirty slot; uses wbbc_pkg.
module wbbc_scan #(
    parameter int IDX_W = 2,
    parameter int BLK_W = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       step,
    input  logic [IDX_W-1:0]           ptr,
    input  logic                       slot_valid,
    input  logic                       slot_dirty,
    input  logic [BLK_W-1:0]           slot_tag,
    input  logic [wbbc_pkg::AGE_W-1:0] slot_age,
    input  logic [BLK_W-1:0]           blk,
    output wbbc_pkg::scan_flags_t      flags,
    output logic [IDX_W-1:0]           hit_idx,
    output logic [IDX_W-1:0]           empty_idx,
    output logic [IDX_W-1:0]           clean_idx,
    output logic [IDX_W-1:0]           dirty_idx,
    output logic [BLK_W-1:0]           dirty_tag
);
    import wbbc_pkg::*;

    scan_flags_t        flags_reg;
    scan_flags_t        flags_next;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   empty_idx_reg;
    logic [IDX_W-1:0]   clean_idx_reg;
    logic [IDX_W-1:0]   dirty_idx_reg;
    logic [BLK_W-1:0]   dirty_tag_reg;
    logic [AGE_W-1:0]   clean_age_reg;
    logic [AGE_W-1:0]   dirty_age_reg;

    logic               tag_eq;
    logic               best_found;
    logic [AGE_W-1:0]   best_age;
    logic               age_lt;
    logic               take_hit;
    logic               take_empty;
    logic               take;

    // Shared compare: match against the block, age against the class best
    assign tag_eq     = slot_valid && (slot_tag == blk);
    assign best_found = slot_dirty ? flags_reg.dirty : flags_reg.clean;
    assign best_age   = slot_dirty ? dirty_age_reg : clean_age_reg;
    assign age_lt     = slot_age < best_age;
    assign take       = slot_valid && (!best_found || age_lt);
    assign take_hit   = tag_eq && !flags_reg.hit;
    assign take_empty = !slot_valid && !flags_reg.empty;

    always_comb
    begin
        flags_next = flags_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else if (step)
        begin
            if (take_hit)
            begin
                flags_next.hit = 1'b1;
            end
            if (take_empty)
            begin
                flags_next.empty = 1'b1;
            end
            if (take && slot_dirty)
            begin
                flags_next.dirty = 1'b1;
            end
            if (take && !slot_dirty)
            begin
                flags_next.clean = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // Capture the winning slot of each class
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (take_hit)
            begin
                hit_idx_reg <= ptr;
            end
            if (take_empty)
            begin
                empty_idx_reg <= ptr;
            end
            if (take && slot_dirty)
            begin
                dirty_idx_reg <= ptr;
                dirty_age_reg <= slot_age;
                dirty_tag_reg <= slot_tag;
            end
            if (take && !slot_dirty)
            begin
                clean_idx_reg <= ptr;
                clean_age_reg <= slot_age;
            end
        end
    end

    assign flags     = flags_reg;
    assign hit_idx   = hit_idx_reg;
    assign empty_idx = empty_idx_reg;
    assign clean_idx = clean_idx_reg;
    assign dirty_idx = dirty_idx_reg;
    assign dirty_tag = dirty_tag_reg;

endmodule

FILE: rtl/write_back_block_cache_policy_core.sv
// Write-back block cache policy core: slot state, sequencer and result register.
// Instantiates wbbc_split and wbbc_scan; uses wbbc_pkg.
//
// Tag and replacement controller for a small fully associative write-back cache
// of erase blocks. Each request carries an op and a sector; results leave one
// at a time through a registered output, the final one of a request marked by
// tlast. Slots are walked by a single compare unit, one slot per clock; a read,
// write or commit-oldest request walks every slot, and a write that evicts a
// dirty slot reports its commit before its final result. A flush walks the
// slots once, up to and including the last dirty one, emitting one commit per
// dirty slot; an out-of-range sector or a flush with nothing dirty goes
// straight to the final result. A waiting result stalls the sequencer only
// when a new result is ready; the core takes the next request while its final
// result waits.
module write_back_block_cache_policy_core #(
    parameter int SLOTS             = wbbc_pkg::SLOTS_DEF,
    parameter int SECTORS_PER_BLOCK = wbbc_pkg::SPB_DEF,
    parameter int TOTAL_SECTORS     = wbbc_pkg::TOTAL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // op [1:0], sector [13:2], zero [15:14]
    input  logic [wbbc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // status [0], hit [1], slot [3:2], sector_offset [6:4], fill_needed [7],
    // fill_block [15:8], commit_valid [16], commit_slot [18:17],
    // commit_block [26:19], dirty_count [29:27], zero [31:30]
    output logic [wbbc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import wbbc_pkg::*;

    localparam int IdxW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CntW    = $clog2(SLOTS + 1);
    localparam int BlkRaw  = $clog2((TOTAL_SECTORS - 1) / SECTORS_PER_BLOCK + 1);
    localparam int BlkW    = (BlkRaw > 0) ? BlkRaw : 1;
    localparam int OffW    = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DECIDE  = 3'd2;
    localparam logic [2:0] ST_VCOMMIT = 3'd3;
    localparam logic [2:0] ST_RESULT  = 3'd4;
    localparam logic [2:0] ST_FLUSH   = 3'd5;

    // Narrow or widen internal values to the result field widths
    function automatic logic [1:0] slot_field(input logic [IdxW-1:0] i);
        logic [IdxW+1:0] w;
        w = {2'b00, i};
        return w[1:0];
    endfunction

    function automatic logic [7:0] blk_field(input logic [BlkW-1:0] b);
        logic [BlkW+7:0] w;
        w = {8'h00, b};
        return w[7:0];
    endfunction

    function automatic logic [2:0] cnt_field(input logic [CntW-1:0] c);
        logic [CntW+2:0] w;
        w = {3'b000, c};
        return w[2:0];
    endfunction

    function automatic logic [2:0] off_field(input logic [OffW-1:0] o);
        logic [OffW+2:0] w;
        w = {3'b000, o};
        return w[2:0];
    endfunction

    // Control state
    logic [2:0]        state_reg,     state_next;
    op_t               op_reg,        op_next;
    logic              reject_reg,    reject_next;
    logic [IdxW-1:0]   ptr_reg,       ptr_next;
    logic [IdxW-1:0]   idx_reg,       idx_next;
    logic              fill_reg,      fill_next;
    logic [SLOTS-1:0]  valid_reg,     valid_next;
    logic [SLOTS-1:0]  dirty_reg,     dirty_next;
    logic [CntW-1:0]   dcount_reg,    dcount_next;
    logic [AGE_W-1:0]  age_clock_reg, age_clock_next;
    logic              m_tvalid_reg;

    // Slot payload
    logic [BlkW-1:0]   tag_reg [SLOTS];
    logic [AGE_W-1:0]  age_reg [SLOTS];
    logic              slot_we;
    logic              tag_we;

    // Result register
    result_t           m_tdata_reg;
    logic              m_tlast_reg;
    result_t           res;
    logic              res_last;
    logic              emit;

    // Handshake and request fields
    logic              accept;
    logic              out_free;
    op_t               in_op;
    logic [SECTOR_W-1:0] in_sector;
    logic              in_range;

    // Unit outputs
    logic [BlkW-1:0]   blk;
    logic [OffW-1:0]   offset;
    scan_flags_t       flags;
    logic [IdxW-1:0]   hit_idx;
    logic [IdxW-1:0]   empty_idx;
    logic [IdxW-1:0]   clean_idx;
    logic [IdxW-1:0]   dirty_idx;
    logic [BlkW-1:0]   dirty_tag;
    logic [BlkW-1:0]   tag_rd;
    logic [AGE_W-1:0]  age_rd;
    logic [IdxW-1:0]   victim;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_op     = op_t'(s_tdata[1:0]);
    assign in_sector = s_tdata[13:2];
    assign in_range  = {1'b0, in_sector} < (SECTOR_W + 1)'(TOTAL_SECTORS);

    // Single read port on the slot payload, at the walk pointer
    assign tag_rd = tag_reg[ptr_reg];
    assign age_rd = age_reg[ptr_reg];

    wbbc_split #(
        .SPB   (SECTORS_PER_BLOCK),
        .BLK_W (BlkW),
        .OFF_W (OffW)
    ) u_split (
        .clk    (clk),
        .load   (accept),
        .sector (in_sector),
        .blk    (blk),
        .offset (offset)
    );

    wbbc_scan #(
        .IDX_W (IdxW),
        .BLK_W (BlkW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept),
        .step       (state_reg == ST_SCAN),
        .ptr        (ptr_reg),
        .slot_valid (valid_reg[ptr_reg]),
        .slot_dirty (dirty_reg[ptr_reg]),
        .slot_tag   (tag_rd),
        .slot_age   (age_rd),
        .blk        (blk),
        .flags      (flags),
        .hit_idx    (hit_idx),
        .empty_idx  (empty_idx),
        .clean_idx  (clean_idx),
        .dirty_idx  (dirty_idx),
        .dirty_tag  (dirty_tag)
    );

    // Replacement order: first empty, else oldest clean, else oldest dirty
    assign victim = flags.empty ? empty_idx : (flags.clean ? clean_idx : dirty_idx);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        reject_next    = reject_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        dcount_next    = dcount_reg;
        age_clock_next = age_clock_reg;
        slot_we        = 1'b0;
        tag_we         = 1'b0;
        emit           = 1'b0;
        res            = '0;
        res_last       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    ptr_next    = '0;
                    reject_next = 1'b0;
                    priority if (in_op == OP_FLUSH)
                    begin
                        state_next = (dcount_reg == '0) ? ST_RESULT : ST_FLUSH;
                    end
                    else if (in_op == OP_COMMIT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (!in_range)
                    begin
                        reject_next = 1'b1;
                        state_next  = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // Walk one slot per cycle through the compare unit
            ST_SCAN:
            begin
                if (ptr_reg == LastIdx)
                begin
                    ptr_next   = '0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    ptr_next = ptr_reg + IdxW'(1);
                end
            end

            // Pick the target slot of a write
            ST_DECIDE:
            begin
                if (op_reg == OP_WRITE && !flags.hit)
                begin
                    idx_next   = victim;
                    fill_next  = 1'b1;
                    state_next = (!flags.empty && !flags.clean) ? ST_VCOMMIT : ST_RESULT;
                end
                else
                begin
                    idx_next   = hit_idx;
                    fill_next  = 1'b0;
                    state_next = ST_RESULT;
                end
            end

            // Report the dirty victim before the fill
            ST_VCOMMIT:
            begin
                if (out_free)
                begin
                    emit                = 1'b1;
                    res.commit_valid    = 1'b1;
                    res.commit_slot     = slot_field(idx_reg);
                    res.commit_block    = blk_field(dirty_tag);
                    dcount_next         = dcount_reg - CntW'(1);
                    res.dirty_count     = cnt_field(dcount_next);
                    dirty_next[idx_reg] = 1'b0;
                    state_next          = ST_RESULT;
                end
            end

            // Final result of the request
            ST_RESULT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res_last   = 1'b1;
                    state_next = ST_IDLE;
                    priority if (reject_reg)
                    begin
                        res.status      = 1'b1;
                        res.dirty_count = cnt_field(dcount_reg);
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_READ:
                            begin
                                res.hit           = flags.hit;
                                res.slot          = flags.hit ? slot_field(hit_idx) : 2'b00;
                                res.sector_offset = off_field(offset);
                                res.dirty_count   = cnt_field(dcount_reg);
                            end
                            OP_WRITE:
                            begin
                                slot_we             = 1'b1;
                                tag_we              = fill_reg;
                                age_clock_next      = age_clock_reg + AGE_W'(1);
                                valid_next[idx_reg] = 1'b1;
                                dirty_next[idx_reg] = 1'b1;
                                dcount_next         = dirty_reg[idx_reg] ? dcount_reg
                                                                         : dcount_reg + CntW'(1);
                                res.hit             = !fill_reg;
                                res.slot            = slot_field(idx_reg);
                                res.sector_offset   = off_field(offset);
                                res.fill_needed     = fill_reg;
                                res.fill_block      = fill_reg ? blk_field(blk) : 8'h00;
                                res.dirty_count     = cnt_field(dcount_next);
                            end
                            OP_COMMIT:
                            begin
                                if (flags.dirty)
                                begin
                                    res.commit_valid      = 1'b1;
                                    res.commit_slot       = slot_field(dirty_idx);
                                    res.commit_block      = blk_field(dirty_tag);
                                    dirty_next[dirty_idx] = 1'b0;
                                    dcount_next           = dcount_reg - CntW'(1);
                                end
                                res.dirty_count = cnt_field(dcount_next);
                            end
                            OP_FLUSH:
                            begin
                                res.dirty_count = cnt_field(dcount_reg);
                            end
                            default:
                            begin
                                res.dirty_count = cnt_field(dcount_reg);
                            end
                        endcase
                    end
                end
            end

            // Commit every dirty slot in index order
            ST_FLUSH:
            begin
                if (dirty_reg[ptr_reg])
                begin
                    if (out_free)
                    begin
                        emit                = 1'b1;
                        res_last            = (dcount_reg == CntW'(1));
                        res.commit_valid    = 1'b1;
                        res.commit_slot     = slot_field(ptr_reg);
                        res.commit_block    = blk_field(tag_rd);
                        dcount_next         = dcount_reg - CntW'(1);
                        res.dirty_count     = cnt_field(dcount_next);
                        dirty_next[ptr_reg] = 1'b0;
                        if (dcount_reg == CntW'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + IdxW'(1);
                        end
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + IdxW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_READ;
            reject_reg    <= 1'b0;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            fill_reg      <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            dcount_reg    <= '0;
            age_clock_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            reject_reg    <= reject_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            dcount_reg    <= dcount_next;
            age_clock_reg <= age_clock_next;
        end
    end

    // Slot payload writes at the target slot
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            age_reg[idx_reg] <= age_clock_next;
        end
        if (tag_we)
        begin
            tag_reg[idx_reg] <= blk;
        end
    end

    // Output register: load a new result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= res;
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
